@@ sv/tt4_pkg.sv @@
// ----------------------------------------------------------------------------
// tt4_pkg
// Shared constants for the 4-way bucketed transposition table: table
// geometry, operation and bound codes, and the layout of a data word.
// ----------------------------------------------------------------------------
package tt4_pkg;

	// Table geometry. BUCKETS must be a power of two; the bucket index is
	// the low bits of the key.
	localparam int BUCKETS = 1024;
	localparam int WAYS    = 4;
	localparam int KEY_W   = 64;
	localparam int WORD_W  = 64;
	localparam int ROW_W   = WAYS * KEY_W;
	localparam int ROW_AW  = $clog2(BUCKETS);
	localparam int WAY_AW  = $clog2(WAYS);

	// Operation codes.
	localparam logic [1:0] MODE_PROBE = 2'd0;
	localparam logic [1:0] MODE_STORE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Bound kinds.
	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;

	// Scores.
	localparam logic signed [15:0] NO_SCORE  = -16'sd32000;
	localparam logic signed [16:0] MATE_EDGE = 17'sd19000;

	// Data word layout.
	localparam int MOVE_LSB  = 0;
	localparam int MOVE_W    = 24;
	localparam int SCORE_LSB = 24;
	localparam int SCORE_W   = 16;
	localparam int DEPTH_LSB = 40;
	localparam int DEPTH_W   = 8;
	localparam int BOUND_LSB = 48;
	localparam int BOUND_W   = 2;
	localparam int CHECK_LSB = 50;
	localparam int CHECK_W   = 14;

endpackage

@@ sv/tt4_ram.sv @@
// ----------------------------------------------------------------------------
// tt4_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tt4_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/transposition_table_4way_core.sv @@
// ----------------------------------------------------------------------------
// transposition_table_4way_core
// Hashed position store of 4-way buckets with probe, store and clear.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one operation per beat: a
// probe, a store or a clear of the whole table. Every operation returns
// exactly one beat on the output channel (out_valid/out_ready).
// A bucket is one row of two RAMs (keys and data words), 4 ways wide. The
// beat's accept edge launches the row read; in the cycle after, the row is
// examined; once the result register is free, it is loaded and a store
// writes the row back. No new probe or store is taken before then.
// A clear returns its beat and then sweeps all 1024 rows, one per cycle,
// before the next beat is taken.
// After reset the same sweep zeroes the table; in_ready stays
// low until it is done.
// If the receiver stalls, the result holds in its register; the block
// takes one more beat and waits with that row read until the register
// frees up.
// ----------------------------------------------------------------------------
module transposition_table_4way_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [63:0]        key,
	input  logic signed [15:0] window_low,
	input  logic signed [15:0] window_high,
	input  logic [7:0]         search_depth,
	input  logic [7:0]         ply_distance,
	input  logic signed [15:0] score_in,
	input  logic [1:0]         bound_kind,
	input  logic [23:0]        move_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               score_usable,
	output logic signed [15:0] score_out,
	output logic               move_found,
	output logic [23:0]        move_out
);

	import tt4_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_WIPE = 3'b100
	} state_t;

	state_t             state_q;
	logic [ROW_AW-1:0]  wipe_cnt_q;
	logic               out_valid_q;

	// Operation held while its row is read and examined.
	logic [1:0]         mode_q;
	logic [KEY_W-1:0]   key_q;
	logic signed [15:0] alpha_q;
	logic signed [15:0] beta_q;
	logic [7:0]         depth_q;
	logic [7:0]         ply_q;
	logic signed [15:0] score_q;
	logic [1:0]         bound_q;
	logic [23:0]        move_q;

	// Result register.
	logic               usable_q;
	logic signed [15:0] score_out_q;
	logic               found_q;
	logic [23:0]        move_out_q;

	// RAM ports.
	logic               rd_en;
	logic [ROW_AW-1:0]  rd_addr;
	logic               wr_en;
	logic [ROW_AW-1:0]  wr_addr;
	logic [ROW_W-1:0]   key_row;
	logic [ROW_W-1:0]   data_row;
	logic [ROW_W-1:0]   key_wr_row;
	logic [ROW_W-1:0]   data_wr_row;
	logic [ROW_W-1:0]   key_new_row;
	logic [ROW_W-1:0]   data_new_row;

	logic               accept;
	logic               slot_free;
	logic               finish;

	// Row examination.
	logic [KEY_W-1:0]   way_key  [WAYS];
	logic [WORD_W-1:0]  way_word [WAYS];
	logic [WAYS-1:0]    key_eq;
	logic [WAYS-1:0]    key_zero;

	logic [WAY_AW-1:0]  pick;
	logic               slot_found;
	logic [8:0]         best_depth;
	logic signed [16:0] st_score_ext;
	logic signed [16:0] st_score_adj;
	logic [WORD_W-1:0]  new_word;

	logic               hit;
	logic [WORD_W-1:0]  hit_word;
	logic               check_ok;
	logic               depth_ok;
	logic signed [16:0] pr_score_ext;
	logic signed [16:0] pr_score_adj;
	logic signed [16:0] alpha_ext;
	logic signed [16:0] beta_ext;
	logic               bound_ok;
	logic signed [15:0] bound_val;
	logic               probe_found;
	logic               probe_usable;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_LOOK) && slot_free;

	assign rd_en   = accept;
	assign rd_addr = key[ROW_AW-1:0];

	tt4_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(key_wr_row),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(key_row)
	);

	tt4_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_data_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(data_wr_row),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(data_row)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			way_key[w]  = key_row[w*KEY_W +: KEY_W];
			way_word[w] = data_row[w*WORD_W +: WORD_W];
			key_eq[w]   = (way_key[w] == key_q);
			key_zero[w] = (way_key[w] == '0);
		end
	end

	// Store: first way holding this key or empty, else the shallowest way
	// (the first of equal depths).
	always_comb begin
		pick       = '0;
		slot_found = 1'b0;
		best_depth = '1;
		for (int w = 0; w < WAYS; w++) begin
			if (!slot_found) begin
				if (key_eq[w] || key_zero[w]) begin
					pick       = WAY_AW'(w);
					slot_found = 1'b1;
				end else if ({1'b0, way_word[w][DEPTH_LSB +: DEPTH_W]} < best_depth) begin
					best_depth = {1'b0, way_word[w][DEPTH_LSB +: DEPTH_W]};
					pick       = WAY_AW'(w);
				end
			end
		end
	end

	// Mate scores move away from zero by the ply on store.
	always_comb begin
		st_score_ext = {score_q[15], score_q};
		if (st_score_ext > MATE_EDGE) begin
			st_score_adj = st_score_ext + $signed({9'd0, ply_q});
		end else if (st_score_ext < -MATE_EDGE) begin
			st_score_adj = st_score_ext - $signed({9'd0, ply_q});
		end else begin
			st_score_adj = st_score_ext;
		end
	end

	assign new_word = {key_q[CHECK_LSB +: CHECK_W], bound_q, depth_q,
		st_score_adj[15:0], move_q};

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (pick == WAY_AW'(w)) begin
				key_new_row[w*KEY_W +: KEY_W]    = key_q;
				data_new_row[w*WORD_W +: WORD_W] = new_word;
			end else begin
				key_new_row[w*KEY_W +: KEY_W]    = way_key[w];
				data_new_row[w*WORD_W +: WORD_W] = way_word[w];
			end
		end
	end

	// Probe: the first way with an equal key decides.
	always_comb begin
		hit      = 1'b0;
		hit_word = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && key_eq[w]) begin
				hit      = 1'b1;
				hit_word = way_word[w];
			end
		end
	end

	assign check_ok = hit &&
		(hit_word[CHECK_LSB +: CHECK_W] == key_q[CHECK_LSB +: CHECK_W]);
	assign depth_ok = (hit_word[DEPTH_LSB +: DEPTH_W] >= depth_q);

	// Mate scores move back toward zero by the ply on probe.
	always_comb begin
		pr_score_ext = {hit_word[SCORE_LSB + SCORE_W - 1], hit_word[SCORE_LSB +: SCORE_W]};
		if (pr_score_ext > MATE_EDGE) begin
			pr_score_adj = pr_score_ext - $signed({9'd0, ply_q});
		end else if (pr_score_ext < -MATE_EDGE) begin
			pr_score_adj = pr_score_ext + $signed({9'd0, ply_q});
		end else begin
			pr_score_adj = pr_score_ext;
		end
	end

	assign alpha_ext = {alpha_q[15], alpha_q};
	assign beta_ext  = {beta_q[15], beta_q};

	always_comb begin
		bound_ok  = 1'b0;
		bound_val = NO_SCORE;
		case (hit_word[BOUND_LSB +: BOUND_W])
			BOUND_EXACT: begin
				bound_ok  = 1'b1;
				bound_val = pr_score_adj[15:0];
			end
			BOUND_UPPER: begin
				bound_ok  = (pr_score_adj <= alpha_ext);
				bound_val = alpha_q;
			end
			BOUND_LOWER: begin
				bound_ok  = (pr_score_adj >= beta_ext);
				bound_val = beta_q;
			end
			default: begin
				bound_ok  = 1'b0;
				bound_val = NO_SCORE;
			end
		endcase
	end

	assign probe_found  = (mode_q == MODE_PROBE) && check_ok;
	assign probe_usable = probe_found && depth_ok && bound_ok;

	// Write port: the sweep writes zero rows, a store writes back its row.
	assign wr_en       = (finish && (mode_q == MODE_STORE)) || (state_q == ST_WIPE);
	assign wr_addr     = (state_q == ST_WIPE) ? wipe_cnt_q : key_q[ROW_AW-1:0];
	assign key_wr_row  = (state_q == ST_WIPE) ? '0 : key_new_row;
	assign data_wr_row = (state_q == ST_WIPE) ? '0 : data_new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wipe_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (slot_free) begin
						if (mode_q == MODE_CLEAR) begin
							state_q    <= ST_WIPE;
							wipe_cnt_q <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WIPE: begin
					wipe_cnt_q <= wipe_cnt_q + 1'b1;
					if (wipe_cnt_q == ROW_AW'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= key;
			alpha_q <= window_low;
			beta_q  <= window_high;
			depth_q <= search_depth;
			ply_q   <= ply_distance;
			score_q <= score_in;
			bound_q <= bound_kind;
			move_q  <= move_in;
		end
		if (finish) begin
			usable_q    <= probe_usable;
			score_out_q <= probe_usable ? bound_val : NO_SCORE;
			found_q     <= probe_found;
			move_out_q  <= probe_found ? hit_word[MOVE_LSB +: MOVE_W] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign score_usable = usable_q;
	assign score_out    = score_out_q;
	assign move_found   = found_q;
	assign move_out     = move_out_q;

endmodule

@@ sv/tt4_checker.sv @@
// ----------------------------------------------------------------------------
// tt4_checker
// Port-level checks for the transposition table core, bound into the core.
// ----------------------------------------------------------------------------
module tt4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               score_usable,
	input logic signed [15:0] score_out,
	input logic               move_found,
	input logic [23:0]        move_out
);

	import tt4_pkg::*;

	// Only one operation is in flight, so ready drops after every accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// A usable score requires a matched entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && score_usable |-> move_found)
		else $error("usable score without a matched entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !score_usable |-> score_out == NO_SCORE)
		else $error("unusable result carries a score");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !move_found |-> move_out == '0)
		else $error("move reported without a match");

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score_out) && $stable(move_out))
		else $error("stalled result changed");

endmodule

bind transposition_table_4way_core tt4_checker u_tt4_checker (.*);
